[rtl/kwm_pkg.sv]
// Shared constants, codes and the result record for the k-way run merge.
package kwm_pkg;

  localparam int KEY_W            = 32;
  localparam int NUM_WAYS_DEFAULT = 8;
  localparam int RUN_LEN_DEFAULT  = 256;

  localparam logic [KEY_W-1:0] SENTINEL_RESET = 32'h7F80_0000;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [2:0]       source_way;
    logic             exhausted;
    logic             last;
  } kwm_result_t;

endpackage

[rtl/kwm_store.sv]
// Run store: single write port, single registered read port.
module kwm_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [kwm_pkg::KEY_W-1:0] wr_data,
  input  logic [AW-1:0]           rd_addr,
  output logic [kwm_pkg::KEY_W-1:0] rd_data
);
  import kwm_pkg::*;

  logic [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/kwm_scan.sv]
// Pop sequencer: walks the way heads through one shared comparator.
module kwm_scan #(
  parameter int NUM_WAYS = 8,
  parameter int RUN_LEN  = 256,
  localparam int DEPTH   = NUM_WAYS * RUN_LEN,
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      func,
  input  logic [2:0]                way,
  input  logic [7:0]                position,
  input  logic [kwm_pkg::KEY_W-1:0] key_in,
  input  logic [kwm_pkg::KEY_W-1:0] sentinel,
  output logic                      busy,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [kwm_pkg::KEY_W-1:0] wr_data,
  output logic [AW-1:0]             rd_addr,
  input  logic [kwm_pkg::KEY_W-1:0] rd_data,
  output logic                      res_valid,
  output kwm_pkg::kwm_result_t      res
);
  import kwm_pkg::*;

  localparam int IW = $clog2(NUM_WAYS);
  localparam int PW = $clog2(RUN_LEN + 1);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [AW-1:0] RUN_STEP  = AW'(RUN_LEN);
  localparam logic [PW-1:0] PTR_END   = PW'(RUN_LEN);
  localparam logic [CW-1:0] POP_FULL  = CW'(DEPTH);
  localparam logic [IW-1:0] WAY_LAST  = IW'(NUM_WAYS - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]       state;
  logic [IW-1:0]    idx;
  logic [AW-1:0]    base;
  logic [PW-1:0]    ptr [NUM_WAYS];
  logic [CW-1:0]    pop_count;
  logic             s1_valid;
  logic             s1_live;
  logic [IW-1:0]    s1_way;
  logic [PW-1:0]    s1_ptr;
  logic [KEY_W-1:0] best;
  logic [IW-1:0]    best_way;
  logic [PW-1:0]    best_ptr;
  logic             found;

  logic             accept;
  logic             load_hit;
  logic             pop_go;
  logic             in_range;
  logic [PW-1:0]    head_ptr;
  logic             head_live;
  logic             better;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign load_hit  = accept && (func == FUNC_LOAD);
  assign pop_go    = accept && (func == FUNC_POP);
  assign in_range  = (32'(way) < 32'(NUM_WAYS)) && (32'(position) < 32'(RUN_LEN));

  assign wr_en   = load_hit && in_range;
  assign wr_addr = AW'(AW'(way) * RUN_STEP + AW'(position));
  assign wr_data = key_in;

  assign head_ptr  = ptr[idx];
  assign head_live = (head_ptr < PTR_END);
  assign rd_addr   = AW'(base + AW'(head_ptr));

  assign better = s1_valid && s1_live && (rd_data < best);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      found     <= 1'b0;
      pop_count <= '0;
      for (int i = 0; i < NUM_WAYS; i++) begin
        ptr[i] <= '0;
      end
    end else begin
      res_valid <= (state == ST_FINISH);
      s1_valid  <= (state == ST_SCAN);

      unique case (state)
        ST_IDLE: begin
          if (pop_go) begin
            state <= ST_SCAN;
            idx   <= '0;
            base  <= '0;
            best  <= sentinel;
            found <= 1'b0;
          end
        end
        ST_SCAN: begin
          // issue one head read per cycle; compare lands in the next cycle
          s1_live  <= head_live;
          s1_way   <= idx;
          s1_ptr   <= head_ptr;
          base     <= AW'(base + RUN_STEP);
          idx      <= IW'(idx + IW'(1));
          if (idx == WAY_LAST) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          state     <= ST_IDLE;
          if (found) begin
            res.key        <= best;
            res.source_way <= 3'(best_way);
            res.exhausted  <= 1'b0;
            res.last       <= ((pop_count + CW'(1)) == POP_FULL);
            ptr[best_way]  <= PW'(best_ptr + PW'(1));
            pop_count      <= CW'(pop_count + CW'(1));
          end else begin
            res.key        <= sentinel;
            res.source_way <= 3'd0;
            res.exhausted  <= 1'b1;
            res.last       <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (better) begin
        best     <= rd_data;
        best_way <= s1_way;
        best_ptr <= s1_ptr;
        found    <= 1'b1;
      end

      if (load_hit) begin
        pop_count <= '0;
        for (int i = 0; i < NUM_WAYS; i++) begin
          ptr[i] <= '0;
        end
      end
    end
  end

  a_res_after_finish: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(state == ST_FINISH))
    else $error("result strobe without a finished scan");

  a_exhausted_fields: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.exhausted) |-> (res.source_way == 3'd0 && !res.last))
    else $error("exhausted result carries a way or last flag");

  a_key_below_sentinel: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.exhausted) |-> (res.key < sentinel))
    else $error("emitted key not below sentinel");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (!busy && !(start && func == FUNC_POP)) |=> !busy)
    else $error("sequencer left idle without a pop request");

endmodule

[rtl/k_way_sorted_run_merge.sv]
// Top level of the k-way sorted-run merge: sentinel register, run store and pop sequencer.
//
//  channel   ports                                        handshake
//  -------   -------------------------------------------  ---------------------------------
//  request   func, way, position, key_in                  taken when start && !busy
//  config    cfg_data (sentinel_key)                      written when cfg_valid && cfg_ready
//  result    key_out, source_way, exhausted, last         shown one cycle with result_valid
//
//  A load request never raises busy; it writes the store if way and position are in range
//  and restarts the merge. A pop request holds busy while it walks the ways through the
//  single head comparator (store read port feeds it), drains the read pipe and commits.
//  The result strobe rises as busy falls; the receiver cannot stall it.
//  cfg_ready drops while busy or start is high, so the sentinel never moves under a pop.
//  Reset clears the pointers, the pop count and the sentinel (to +infinity); the run store
//  is not cleared and holds garbage until loaded.
module k_way_sorted_run_merge #(
  parameter int NUM_WAYS = kwm_pkg::NUM_WAYS_DEFAULT,
  parameter int RUN_LEN  = kwm_pkg::RUN_LEN_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      func,
  input  logic [2:0]                way,
  input  logic [7:0]                position,
  input  logic [kwm_pkg::KEY_W-1:0] key_in,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [kwm_pkg::KEY_W-1:0] cfg_data,
  output logic                      result_valid,
  output logic [kwm_pkg::KEY_W-1:0] key_out,
  output logic [2:0]                source_way,
  output logic                      exhausted,
  output logic                      last
);
  import kwm_pkg::*;

  localparam int DEPTH = NUM_WAYS * RUN_LEN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [KEY_W-1:0] sentinel;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_data;
  kwm_result_t      res;

  // Hold off sentinel writes while a pop is scanning against it or being taken.
  assign cfg_ready = !busy && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      sentinel <= SENTINEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sentinel <= cfg_data;
    end
  end

  // Run store: way-major, one run of RUN_LEN keys after another.
  kwm_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: loads go straight to the store; pops scan the heads one way per cycle.
  kwm_scan #(
    .NUM_WAYS (NUM_WAYS),
    .RUN_LEN  (RUN_LEN)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (func),
    .way       (way),
    .position  (position),
    .key_in    (key_in),
    .sentinel  (sentinel),
    .busy      (busy),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (result_valid),
    .res       (res)
  );

  // Unpack the registered result record onto the result ports.
  assign key_out    = res.key;
  assign source_way = res.source_way;
  assign exhausted  = res.exhausted;
  assign last       = res.last;

endmodule

[bench/k_way_sorted_run_merge_tb.sv]
// Self-checking bench for the k-way sorted-run merge: directed table, short merge, random phases.
module k_way_sorted_run_merge_tb;
  import kwm_pkg::*;

  localparam int NUM_WAYS    = NUM_WAYS_DEFAULT;
  localparam int RUN_LEN     = RUN_LEN_DEFAULT;
  localparam int STORE_DEPTH = NUM_WAYS * RUN_LEN;
  localparam int NUM_ROWS    = 23;
  localparam int NUM_PHASES  = 4;
  localparam int MERGE_LEN   = 8;

  // One row of the directed table. A row with typed set carries its own
  // expected result; every other pop row is checked against the predictor.
  typedef struct packed {
    logic        func;
    logic [2:0]  way;
    logic [7:0]  pos;
    logic [31:0] key;
    logic        typed;
    kwm_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        func = FUNC_LOAD;
  logic [2:0]  way = '0;
  logic [7:0]  position = '0;
  logic [31:0] key_in = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        result_valid;
  logic [31:0] key_out;
  logic [2:0]  source_way;
  logic        exhausted;
  logic        last;

  // Predictor state: private copy of the run store, which entries were
  // ever loaded, head pointers, successful pop count and the sentinel.
  logic [31:0] run_copy [STORE_DEPTH];
  bit          entry_loaded [STORE_DEPTH];
  logic [8:0]  head_ptr [NUM_WAYS];
  logic [11:0] merged_count;
  logic [31:0] model_sentinel;

  kwm_result_t awaited_pops [$];
  kwm_result_t front_want;
  stim_row_t   directed_rows [NUM_ROWS];
  logic [31:0] phase_sentinel [NUM_PHASES];
  int          phase_items [NUM_PHASES];
  int          mismatch_count = 0;
  bit          no_idle_mode = 1'b0;

  k_way_sorted_run_merge #(
    .NUM_WAYS(NUM_WAYS),
    .RUN_LEN (RUN_LEN)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .way         (way),
    .position    (position),
    .key_in      (key_in),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .result_valid(result_valid),
    .key_out     (key_out),
    .source_way  (source_way),
    .exhausted   (exhausted),
    .last        (last)
  );

  always #5 clk = ~clk;

  // Apply one accepted request to the predictor. Returns 1 when the request
  // produces a result (every pop), with the expected result in res.
  function automatic bit merge_step(input logic f, input logic [2:0] w, input logic [7:0] p,
                                    input logic [31:0] k, output kwm_result_t res);
    logic [31:0] best;
    logic [31:0] head;
    bit          found;
    int          best_way;
    res = '0;
    if (f == FUNC_LOAD) begin
      // Drop out-of-range writes; every load restarts the merge anyway.
      if (int'(w) < NUM_WAYS && int'(p) < RUN_LEN) begin
        run_copy[int'(w) * RUN_LEN + int'(p)]     = k;
        entry_loaded[int'(w) * RUN_LEN + int'(p)] = 1'b1;
      end
      for (int i = 0; i < NUM_WAYS; i++) head_ptr[i] = '0;
      merged_count = '0;
      return 1'b0;
    end
    best     = model_sentinel;
    found    = 1'b0;
    best_way = 0;
    // Scan the heads in way order; strict compare keeps the lowest way on ties.
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (int'(head_ptr[i]) < RUN_LEN) begin
        head = run_copy[i * RUN_LEN + int'(head_ptr[i])];
        if (head < best) begin
          best     = head;
          best_way = i;
          found    = 1'b1;
        end
      end
    end
    if (!found) begin
      // Nothing below the sentinel: emit it, move no pointer.
      res.key       = model_sentinel;
      res.exhausted = 1'b1;
      return 1'b1;
    end
    head_ptr[best_way] = head_ptr[best_way] + 9'd1;
    merged_count       = merged_count + 12'd1;
    res.key        = best;
    res.source_way = best_way[2:0];
    res.last       = (merged_count == 12'(STORE_DEPTH));
    return 1'b1;
  endfunction

  // First way whose current head was never loaded, or -1 when a pop reads
  // only loaded entries.
  function automatic int unloaded_head();
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (int'(head_ptr[i]) < RUN_LEN && !entry_loaded[i * RUN_LEN + int'(head_ptr[i])])
        return i;
    end
    return -1;
  endfunction

  // Mostly short gaps, a few long ones; none at all in a no-idle phase.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle_mode) return 0;
    if (r < 60) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // Keys for the random phases: full range, extremes, tiny values and
  // values below the current sentinel so that heads qualify.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      2: return $urandom_range(0, 15);
      default: return (model_sentinel == 32'h0) ? 32'h0 : $urandom_range(0, model_sentinel - 1);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic drive_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Present one request, hold it until the block takes it, then predict.
  // A typed expectation replaces the predicted one; the predictor still runs
  // so that its state follows the block.
  task automatic issue_request(input logic f, input logic [2:0] w, input logic [7:0] p,
                               input logic [31:0] k, input bit use_typed,
                               input kwm_result_t typed_want);
    kwm_result_t predicted;
    bit          has_res;
    drive_gap(pick_gap());
    @(negedge clk);
    start    <= 1'b1;
    func     <= f;
    way      <= w;
    position <= p;
    key_in   <= k;
    do @(posedge clk); while (busy !== 1'b0);
    has_res = merge_step(f, w, p, k, predicted);
    if (has_res) awaited_pops.push_back(use_typed ? typed_want : predicted);
  endtask

  task automatic issue_load(input logic [2:0] w, input logic [7:0] p, input logic [31:0] k);
    issue_request(FUNC_LOAD, w, p, k, 1'b0, '0);
  endtask

  // Pop when every head the scan reads was loaded; otherwise load the
  // first unloaded head instead, which restarts the merge.
  task automatic issue_pop();
    int w;
    w = unloaded_head();
    if (w < 0)
      issue_request(FUNC_POP, 3'($urandom), 8'($urandom), $urandom, 1'b0, '0);
    else
      issue_load(3'(w), 8'(head_ptr[w]), pick_key());
  endtask

  // Drop start, wait for every pending pop to come back plus a pop's worth
  // of cycles, then write the sentinel through its own channel.
  task automatic write_sentinel(input logic [31:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (awaited_pops.size() != 0) @(posedge clk);
    repeat (NUM_WAYS + 4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    model_sentinel = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Fill the first MERGE_LEN entries of every way with ascending runs and
  // cap each run with an all-ones key, which the all-ones sentinel ignores.
  // Pop the whole merge and one more, which finds only caps and exhausts.
  task automatic run_short_merge();
    logic [31:0] run_key;
    logic [31:0] step_max;
    for (int w = 0; w < NUM_WAYS; w++) begin
      run_key  = $urandom_range(0, 32'h7FFF_FFFF);
      step_max = $urandom_range(0, 1) ? 32'd3 : 32'h007F_FFFF;
      for (int p = 0; p < MERGE_LEN; p++) begin
        issue_load(w[2:0], p[7:0], run_key);
        run_key = run_key + $urandom_range(0, step_max);
      end
      issue_load(w[2:0], 8'(MERGE_LEN), 32'hFFFF_FFFF);
    end
    repeat (NUM_WAYS * MERGE_LEN + 1) issue_pop();
  endtask

  // Mostly well-formed sequences: a few loads near the run heads, then a
  // burst of pops (now and then a long one). The rest is single loads and
  // single pops at random.
  task automatic run_mixed_phase(input int items);
    int issued;
    int loads;
    int pops;
    int pos;
    issued = 0;
    while (issued < items) begin
      case ($urandom_range(0, 9))
        8: begin
          issue_load(3'($urandom), 8'($urandom), $urandom);
          issued++;
        end
        9: begin
          issue_pop();
          issued++;
        end
        default: begin
          loads = $urandom_range(1, 6);
          repeat (loads) begin
            pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, RUN_LEN - 1)
                                              : $urandom_range(0, 3);
            issue_load(3'($urandom), pos[7:0], pick_key());
          end
          pops = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
          if (issued + loads + pops > items)
            pops = (items > issued + loads) ? items - issued - loads : 0;
          repeat (pops) issue_pop();
          issued += loads + pops;
        end
      endcase
    end
  endtask

  // Check each strobed result against the oldest pending expectation.
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) begin
      if (awaited_pops.size() == 0) begin
        report_mismatch("result with nothing pending, key", key_out, 32'h0);
      end else begin
        front_want = awaited_pops.pop_front();
        if (key_out !== front_want.key)
          report_mismatch("key_out", key_out, front_want.key);
        if (source_way !== front_want.source_way)
          report_mismatch("source_way", 32'(source_way), 32'(front_want.source_way));
        if (exhausted !== front_want.exhausted)
          report_mismatch("exhausted", 32'(exhausted), 32'(front_want.exhausted));
        if (last !== front_want.last)
          report_mismatch("last", 32'(last), 32'(front_want.last));
      end
    end
  end

  initial begin
    // Heads at position 0 cover the key extremes, a tie between ways 1
    // and 2, a head equal to the sentinel and one above it. Follow-on
    // entries hold an unsorted run in way 3 and push every way past the
    // sentinel, so the last pop finds nothing and reports exhaustion.
    directed_rows = '{
      '{FUNC_LOAD, 3'd0, 8'd0, 32'h7F7F_FFFF, 1'b0, '0},
      '{FUNC_LOAD, 3'd1, 8'd0, 32'h0000_0000, 1'b0, '0},
      '{FUNC_LOAD, 3'd2, 8'd0, 32'h0000_0000, 1'b0, '0},
      '{FUNC_LOAD, 3'd3, 8'd0, 32'h3F80_0000, 1'b0, '0},
      '{FUNC_LOAD, 3'd4, 8'd0, 32'h7F80_0000, 1'b0, '0},
      '{FUNC_LOAD, 3'd5, 8'd0, 32'hFFFF_FFFF, 1'b0, '0},
      '{FUNC_LOAD, 3'd6, 8'd0, 32'h0000_0001, 1'b0, '0},
      '{FUNC_LOAD, 3'd7, 8'd0, 32'h4000_0000, 1'b0, '0},
      '{FUNC_LOAD, 3'd1, 8'd1, 32'h7F80_0000, 1'b0, '0},
      '{FUNC_LOAD, 3'd2, 8'd1, 32'hFFFF_FFFF, 1'b0, '0},
      '{FUNC_LOAD, 3'd6, 8'd1, 32'h7F80_0000, 1'b0, '0},
      '{FUNC_LOAD, 3'd3, 8'd1, 32'h0000_0005, 1'b0, '0},
      '{FUNC_LOAD, 3'd3, 8'd2, 32'hFFFF_FFFF, 1'b0, '0},
      '{FUNC_LOAD, 3'd7, 8'd1, 32'h7F80_0000, 1'b0, '0},
      '{FUNC_LOAD, 3'd0, 8'd1, 32'hFFFF_FFFF, 1'b0, '0},
      '{FUNC_POP,  3'd0, 8'd0, 32'h0, 1'b1, '{32'h0000_0000, 3'd1, 1'b0, 1'b0}},
      '{FUNC_POP,  3'd0, 8'd0, 32'h0, 1'b1, '{32'h0000_0000, 3'd2, 1'b0, 1'b0}},
      '{FUNC_POP,  3'd0, 8'd0, 32'h0, 1'b0, '0},
      '{FUNC_POP,  3'd0, 8'd0, 32'h0, 1'b0, '0},
      '{FUNC_POP,  3'd0, 8'd0, 32'h0, 1'b0, '0},
      '{FUNC_POP,  3'd0, 8'd0, 32'h0, 1'b0, '0},
      '{FUNC_POP,  3'd0, 8'd0, 32'h0, 1'b0, '0},
      '{FUNC_POP,  3'd0, 8'd0, 32'h0, 1'b1, '{SENTINEL_RESET, 3'd0, 1'b1, 1'b0}}
    };
    // Sentinel settings for the random phases; zero makes every pop exhaust.
    phase_sentinel[0] = 32'h0000_0000;
    phase_sentinel[1] = $urandom;
    phase_sentinel[2] = SENTINEL_RESET;
    phase_sentinel[3] = 32'h4000_0000;
    phase_items[0]    = 100;
    phase_items[1]    = 380;
    phase_items[2]    = 380;
    phase_items[3]    = 380;

    // Predictor reset state mirrors the block's reset.
    for (int i = 0; i < NUM_WAYS; i++) head_ptr[i] = '0;
    merged_count   = '0;
    model_sentinel = SENTINEL_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table against the reset sentinel.
    for (int r = 0; r < NUM_ROWS; r++)
      issue_request(directed_rows[r].func, directed_rows[r].way, directed_rows[r].pos,
                    directed_rows[r].key, directed_rows[r].typed, directed_rows[r].want);

    // Short merge under the all-ones sentinel; later pops load any head
    // that was never written before they read it.
    write_sentinel(32'hFFFF_FFFF);
    run_short_merge();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_sentinel(phase_sentinel[ph]);
      no_idle_mode = (ph == 2);
      run_mixed_phase(phase_items[ph]);
    end

    // Drain: drop start, wait for the last pops, then allow stray strobes.
    @(negedge clk);
    start <= 1'b0;
    while (awaited_pops.size() != 0) @(posedge clk);
    repeat (2 * NUM_WAYS + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop for a hung handshake or a lost result.
  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule
